// File: design/rpb_pkg.sv
package rpb_pkg;

  // mantissa of the fixed-point log is held in Q1.MANT_BITS
  localparam int MANT_BITS = 30;
  localparam int MW = MANT_BITS + 1;

  localparam int NB_W = 9;
  localparam int MD_W = 13;
  localparam int CFG_W = 13;
  localparam int IDX_W = 2;
  localparam int BKT_W = 8;

  localparam logic [IDX_W-1:0] REG_NUM_BUCKETS   = 2'd0;
  localparam logic [IDX_W-1:0] REG_DIST_LIMIT    = 2'd1;
  localparam logic [IDX_W-1:0] REG_BIDIRECTIONAL = 2'd2;

  localparam logic [NB_W-1:0] NUM_BUCKETS_RST = 9'd32;
  localparam logic [MD_W-1:0] DIST_LIMIT_RST  = 13'd128;

endpackage

// File: design/rpb_log_stage.sv
module rpb_log_stage #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [rpb_pkg::MW-1:0]  m_in,
  input  logic [FRAC_BITS-1:0]    frac_in,
  output logic [rpb_pkg::MW-1:0]  m_out,
  output logic [FRAC_BITS-1:0]    frac_out
);
  import rpb_pkg::*;

  logic [2*MW-1:0] sq;
  logic [MW:0]     t;
  logic [MW-1:0]   m_next;
  logic [FRAC_BITS-1:0] frac_next;

  // square, back to Q1.30; a square of 2 or more yields a one bit
  always_comb begin
    sq = m_in * m_in;
    t = sq[MANT_BITS +: MW+1];
    if (t[MW]) begin
      m_next = t[MW:1];
      frac_next = {frac_in[FRAC_BITS-2:0], 1'b1};
    end else begin
      m_next = t[MW-1:0];
      frac_next = {frac_in[FRAC_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_out <= m_next;
      frac_out <= frac_next;
    end
  end

endmodule

// File: design/relative_position_bucket.sv
// throughput: one request per cycle; the whole pipeline holds while the output
// register waits on m_tready
// the log units square once per stage and the divider takes one quotient bit per stage
// reset clears all valid bits and loads the register defaults 32, 128 and 1
module relative_position_bucket #(
  parameter int POS_BITS  = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic                      cfg_we,
  input  logic [rpb_pkg::IDX_W-1:0] cfg_index,
  input  logic [rpb_pkg::CFG_W-1:0] cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // query_pos, key_pos
  input  logic [((2*POS_BITS+7)/8)*8-1:0] s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // bucket
  output logic [rpb_pkg::BKT_W-1:0] m_tdata,
  // config_error
  output logic                      m_tuser
);
  import rpb_pkg::*;

  localparam int XW = (POS_BITS > MD_W) ? POS_BITS : MD_W;
  localparam int NW = 6;
  localparam int LW = NW + FRAC_BITS;
  localparam int SH = XW + MANT_BITS;

  typedef struct packed {
    logic              err;
    logic              near;
    logic [NB_W-1:0]   base;
    logic [NB_W-1:0]   active;
    logic [7:0]        exact;
    logic [POS_BITS-1:0] delta;
  } sb_t;

  typedef struct packed {
    logic [NW-1:0] nd;
    logic [NW-1:0] ne;
    logic [NW-1:0] nm;
  } lg_t;

  logic adv;
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  // configuration registers
  logic [NB_W-1:0] num_buckets;
  logic [MD_W-1:0] dist_limit;
  logic            bidirectional;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_buckets <= NUM_BUCKETS_RST;
      dist_limit <= DIST_LIMIT_RST;
      bidirectional <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_BUCKETS:   num_buckets <= cfg_data[NB_W-1:0];
        REG_DIST_LIMIT:    dist_limit <= cfg_data[MD_W-1:0];
        REG_BIDIRECTIONAL: bidirectional <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // entry stage
  logic                v0;
  logic [POS_BITS-1:0] q0, k0;
  logic [NB_W-1:0]     nb0;
  logic [MD_W-1:0]     md0;
  logic                bd0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q0 <= s_tdata[POS_BITS-1:0];
      k0 <= s_tdata[2*POS_BITS-1:POS_BITS];
      nb0 <= num_buckets;
      md0 <= dist_limit;
      bd0 <= bidirectional;
    end
  end

  // stage 1: distance and bucket split
  sb_t sb1_next;
  logic [NB_W-1:0] act;
  always_comb begin
    act = bd0 ? (nb0 >> 1) : nb0;
    sb1_next.active = act;
    sb1_next.exact = act[8:1];
    sb1_next.err = (act[8:1] == 8'd0) || (md0 <= {5'd0, act[8:1]});
    sb1_next.base = '0;
    if (bd0) begin
      if (k0 > q0) begin
        sb1_next.base = act;
        sb1_next.delta = k0 - q0;
      end else begin
        sb1_next.delta = q0 - k0;
      end
    end else begin
      sb1_next.delta = (q0 > k0) ? (q0 - k0) : '0;
    end
    sb1_next.near = (XW'(sb1_next.delta) < XW'(act[8:1]));
  end

  logic v1;
  sb_t sb1;
  logic [XW-1:0] xd1, xe1, xm1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= v0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb1 <= sb1_next;
      xd1 <= XW'(sb1_next.delta);
      xe1 <= XW'(sb1_next.exact);
      xm1 <= XW'(md0);
    end
  end

  // stage 2: integer part of log2 and normalized mantissa for each lane
  logic [XW-1:0]   xin [3];
  logic [NW-1:0]   nv  [3];
  logic [MW-1:0]   m0v [3];
  logic [SH-1:0]   wide [3];
  assign xin[0] = xd1;
  assign xin[1] = xe1;
  assign xin[2] = xm1;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      nv[l] = '0;
      for (int j = 1; j < XW; j++) begin
        if (xin[l][j]) nv[l] = NW'(j);
      end
      wide[l] = {xin[l], {MANT_BITS{1'b0}}} >> nv[l];
      m0v[l] = wide[l][MW-1:0];
    end
  end

  logic                 vl  [FRAC_BITS+1];
  sb_t                  sbl [FRAC_BITS+1];
  lg_t                  lgl [FRAC_BITS+1];
  logic [MW-1:0]        ml  [FRAC_BITS+1][3];
  logic [FRAC_BITS-1:0] fl  [FRAC_BITS+1][3];

  always_ff @(posedge clk) begin
    if (rst) vl[0] <= 1'b0;
    else if (adv) vl[0] <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sbl[0] <= sb1;
      lgl[0] <= '{nd: nv[0], ne: nv[1], nm: nv[2]};
      for (int l = 0; l < 3; l++) begin
        ml[0][l] <= m0v[l];
        fl[0][l] <= '0;
      end
    end
  end

  // fraction bits of the logs, one per stage
  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_log
    always_ff @(posedge clk) begin
      if (rst) vl[i+1] <= 1'b0;
      else if (adv) vl[i+1] <= vl[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sbl[i+1] <= sbl[i];
        lgl[i+1] <= lgl[i];
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      rpb_log_stage #(.FRAC_BITS(FRAC_BITS)) u_stage (
        .clk      (clk),
        .en       (adv),
        .m_in     (ml[i][l]),
        .frac_in  (fl[i][l]),
        .m_out    (ml[i+1][l]),
        .frac_out (fl[i+1][l])
      );
    end
  end

  // log differences and divider setup
  logic [LW-1:0] ld, le, lm, num, den;
  logic          sat;
  always_comb begin
    ld = {lgl[FRAC_BITS].nd, fl[FRAC_BITS][0]};
    le = {lgl[FRAC_BITS].ne, fl[FRAC_BITS][1]};
    lm = {lgl[FRAC_BITS].nm, fl[FRAC_BITS][2]};
    num = (ld > le) ? (ld - le) : '0;
    den = (lm > le) ? (lm - le) : '0;
    // quotient would reach 1.0, or nothing to divide by
    sat = (den == '0) || (num >= den);
  end

  logic                 vd   [FRAC_BITS+1];
  sb_t                  sbd  [FRAC_BITS+1];
  logic [LW-1:0]        drem [FRAC_BITS+1];
  logic [LW-1:0]        dden [FRAC_BITS+1];
  logic                 dsat [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] dq   [FRAC_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) vd[0] <= 1'b0;
    else if (adv) vd[0] <= vl[FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sbd[0] <= sbl[FRAC_BITS];
      drem[0] <= num;
      dden[0] <= den;
      dsat[0] <= sat;
      dq[0] <= '0;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    logic [LW:0]   r2;
    logic [LW:0]   diff;
    logic          ge;
    always_comb begin
      r2 = {drem[i], 1'b0};
      diff = r2 - {1'b0, dden[i]};
      ge = (r2 >= {1'b0, dden[i]});
    end
    always_ff @(posedge clk) begin
      if (rst) vd[i+1] <= 1'b0;
      else if (adv) vd[i+1] <= vd[i];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sbd[i+1] <= sbd[i];
        dden[i+1] <= dden[i];
        dsat[i+1] <= dsat[i];
        drem[i+1] <= ge ? diff[LW-1:0] : r2[LW-1:0];
        dq[i+1] <= {dq[i][FRAC_BITS-2:0], ge};
      end
    end
  end

  // scale the ratio onto the log buckets
  logic [FRAC_BITS-1:0]      ratio;
  logic [NB_W-1:0]           span;
  logic [FRAC_BITS+NB_W-1:0] prod;
  always_comb begin
    ratio = dsat[FRAC_BITS] ? {FRAC_BITS{1'b1}} : dq[FRAC_BITS];
    span = sbd[FRAC_BITS].active - {1'b0, sbd[FRAC_BITS].exact};
    prod = ratio * span;
  end

  logic            vp;
  sb_t             sbp;
  logic [NB_W-1:0] scaled;

  always_ff @(posedge clk) begin
    if (rst) vp <= 1'b0;
    else if (adv) vp <= vd[FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sbp <= sbd[FRAC_BITS];
      scaled <= prod[FRAC_BITS +: NB_W];
    end
  end

  // final bucket with clamps
  logic [NB_W:0] far_bkt, top, sum;
  logic [BKT_W-1:0] bucket_next;
  always_comb begin
    far_bkt = {1'b0, scaled} + {2'b0, sbp.exact};
    top = {1'b0, sbp.active} - 10'd1;
    if (far_bkt > top) far_bkt = top;
    if (sbp.near) sum = {1'b0, sbp.base} + (NB_W+1)'(sbp.delta);
    else sum = {1'b0, sbp.base} + far_bkt;
    if (sbp.err) bucket_next = '0;
    else if (sum > 10'd255) bucket_next = 8'hff;
    else bucket_next = sum[BKT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= vp;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= bucket_next;
      m_tuser <= sbp.err;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("config_error with nonzero bucket");

  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> {1'b0, m_tdata} < num_buckets)
    else $error("bucket beyond configured count");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    vp && m_tvalid && !m_tready |=> vp)
    else $error("pipeline lost a request during stall");

endmodule
